/* design/opf_pkg.sv */
// opf_pkg: shared types and constants for the orbit proximity filter
// no dependencies
package opf_pkg;
    localparam int unsigned DivBits = 40;
    localparam logic [31:0] EccCircular = 32'd13421772;
    localparam logic [31:0] HalfTurn = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_PERIHELION   = 3'd0,
        REG_ECCENTRICITY = 3'd1,
        REG_INCLINATION  = 3'd2,
        REG_NODE         = 3'd3,
        REG_ARGUMENT     = 3'd4,
        REG_PHASE        = 3'd5
    } t_reg_index;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic [15:0] idx;
        logic        ok_simple;
        logic        t_en;
        logic        p_zero;
        logic [39:0] d;
        logic [39:0] p;
        logic [39:0] rem;
    } t_item;
endpackage

/* design/opf_if.sv */
// opf_if: channel interfaces for orbit items, results and configuration writes
// depends on nothing
interface opf_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] orbit_index;
    logic [31:0] perihelion_distance;
    logic [31:0] eccentricity;
    logic [31:0] inclination;
    logic [31:0] ascending_node;
    logic [31:0] argument_perihelion;
    logic [39:0] perihelion_epoch;
    logic [39:0] orbital_period;
    modport source(output valid, opcode, orbit_index, perihelion_distance, eccentricity,
                   inclination, ascending_node, argument_perihelion, perihelion_epoch,
                   orbital_period, input ready);
    modport sink(input valid, opcode, orbit_index, perihelion_distance, eccentricity,
                 inclination, ascending_node, argument_perihelion, perihelion_epoch,
                 orbital_period, output ready);
endinterface

interface opf_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] matched_index;
    logic        is_close;
    modport source(output valid, matched_index, is_close, input ready);
    modport sink(input valid, matched_index, is_close, output ready);
endinterface

interface opf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* design/orbit_proximity_filter.sv */
// orbit_proximity_filter: top level, query store, simple tests, divider and phase compare
// depends on opf_pkg, opf_if, opf_div_step
//
// channel   dir  handshake     payload
// i_item    in   valid/ready   opcode, index, orbit elements, epoch, period
// o_res     out  valid/ready   matched_index, is_close
// i_cfg     in   valid/ready   register index, data
//
// one item per cycle unless a held result stalls; a test result passes the entry register,
// the 40 remainder steps of the epoch / period divider, then the m, product and output registers
// loads update the query at once and produce no result
// a held result stalls the whole pipeline, nothing is dropped or repeated
// synchronous active-low reset clears limits, query and valid bits
module orbit_proximity_filter #(
    parameter int unsigned INDEX_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    opf_item_if.sink i_item,
    opf_res_if.source o_res,
    opf_cfg_if.sink  i_cfg
);
    import opf_pkg::*;

    localparam int unsigned KeepBits = (INDEX_WIDTH < 16) ? INDEX_WIDTH : 16;
    localparam logic [15:0] IndexMask = 16'((17'd1 << KeepBits) - 17'd1);

    logic [31:0] r_lim_q, r_lim_e, r_lim_i, r_lim_n, r_lim_a;
    logic [23:0] r_lim_phase;
    logic [31:0] r_q_q, r_q_e, r_q_i, r_q_n, r_q_a;
    logic [39:0] r_q_epoch, r_q_period;

    logic w_adv;
    logic w_acc;

    function automatic logic [31:0] fold(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        if (d > HalfTurn) begin
            d = 32'd0 - d;
        end
        return d;
    endfunction

    function automatic logic [31:0] absd(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // configuration
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_q <= '0; r_lim_e <= '0; r_lim_i <= '0;
            r_lim_n <= '0; r_lim_a <= '0; r_lim_phase <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PERIHELION:   r_lim_q <= i_cfg.data;
                REG_ECCENTRICITY: r_lim_e <= i_cfg.data;
                REG_INCLINATION:  r_lim_i <= i_cfg.data;
                REG_NODE:         r_lim_n <= i_cfg.data;
                REG_ARGUMENT:     r_lim_a <= i_cfg.data;
                REG_PHASE:        r_lim_phase <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    assign i_item.ready = w_adv;
    assign w_acc = i_item.valid && w_adv;

    // query store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_q <= '0; r_q_e <= '0; r_q_i <= '0; r_q_n <= '0; r_q_a <= '0;
            r_q_epoch <= '0; r_q_period <= '0;
        end else if (w_acc && i_item.opcode == OP_LOAD) begin
            r_q_q      <= i_item.perihelion_distance;
            r_q_e      <= i_item.eccentricity;
            r_q_i      <= i_item.inclination;
            r_q_n      <= i_item.ascending_node;
            r_q_a      <= i_item.argument_perihelion;
            r_q_epoch  <= i_item.perihelion_epoch;
            r_q_period <= i_item.orbital_period;
        end
    end

    // entry stage: element tests and epoch distance
    t_item w_entry;
    logic  w_ok;
    always_comb begin
        w_ok = 1'b1;
        if (r_lim_q != 0 && !(absd(i_item.perihelion_distance, r_q_q) < r_lim_q)) w_ok = 1'b0;
        if (r_lim_e != 0 && !(absd(i_item.eccentricity, r_q_e) < r_lim_e)) w_ok = 1'b0;
        if (r_lim_i != 0 && !(fold(i_item.inclination, r_q_i) < r_lim_i)) w_ok = 1'b0;
        if (r_lim_n != 0 && !(fold(i_item.ascending_node, r_q_n) < r_lim_n)) w_ok = 1'b0;
        if (r_lim_a != 0 && r_q_e > EccCircular
            && !(fold(i_item.argument_perihelion, r_q_a) < r_lim_a)) w_ok = 1'b0;
        w_entry.idx       = i_item.orbit_index & IndexMask;
        w_entry.ok_simple = w_ok;
        w_entry.t_en      = (r_lim_phase != 0);
        w_entry.p_zero    = (r_q_period == 0);
        w_entry.d         = (i_item.perihelion_epoch > r_q_epoch)
                          ? i_item.perihelion_epoch - r_q_epoch
                          : r_q_epoch - i_item.perihelion_epoch;
        w_entry.p         = r_q_period;
        w_entry.rem       = '0;
    end

    logic  r_v0;
    t_item r_s0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_item.valid && i_item.opcode == OP_TEST;
        end
        if (w_adv) begin
            r_s0 <= w_entry;
        end
    end

    // divider chain, most significant bit first
    logic  w_dv [0:DivBits];
    t_item w_di [0:DivBits];
    assign w_dv[0] = r_v0;
    assign w_di[0] = r_s0;
    for (genvar g = 0; g < DivBits; g++) begin : g_div
        opf_div_step #(.BIT(DivBits - 1 - g)) u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
            .i_valid(w_dv[g]), .i_item(w_di[g]),
            .o_valid(w_dv[g+1]), .o_item(w_di[g+1])
        );
    end

    // (n+1)*p = d - r + p, no multiply needed
    logic        r_vm;
    t_item       r_sm;
    logic [40:0] r_m;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (w_adv) begin
            r_vm <= w_dv[DivBits];
        end
        if (w_adv) begin
            r_sm <= w_di[DivBits];
            r_m  <= {1'b0, w_di[DivBits].d} - {1'b0, w_di[DivBits].rem}
                  + {1'b0, w_di[DivBits].p};
        end
    end

    // limit times m as two partial products
    logic        r_vp;
    t_item       r_sp;
    logic [44:0] r_pp_hi;
    logic [43:0] r_pp_lo;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_adv) begin
            r_vp <= r_vm;
        end
        if (w_adv) begin
            r_sp    <= r_sm;
            r_pp_hi <= {21'd0, r_lim_phase} * {24'd0, r_m[40:20]};
            r_pp_lo <= {20'd0, r_lim_phase} * {24'd0, r_m[19:0]};
        end
    end

    // final compare into output register
    logic        r_vo;
    logic [15:0] r_idx;
    logic        r_close;
    logic [65:0] w_rhs;
    logic [65:0] w_lhs;
    logic        w_tpass;
    always_comb begin
        w_rhs   = {1'b0, r_pp_hi, 20'd0} + {22'd0, r_pp_lo};
        w_lhs   = {2'b00, r_sp.rem, 24'd0};
        w_tpass = !r_sp.t_en || (!r_sp.p_zero && w_lhs < w_rhs);
    end

    assign w_adv = !r_vo || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_adv) begin
            r_vo <= r_vp;
        end
        if (w_adv) begin
            r_idx   <= r_sp.idx;
            r_close <= r_sp.ok_simple && w_tpass;
        end
    end

    assign o_res.valid         = r_vo;
    assign o_res.matched_index = r_idx;
    assign o_res.is_close      = r_close;
endmodule

/* design/opf_div_step.sv */
// opf_div_step: one restoring remainder step of the epoch / period divider
// depends on opf_pkg
module opf_div_step #(
    parameter int unsigned BIT = 39
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  opf_pkg::t_item i_item,
    output logic          o_valid,
    output opf_pkg::t_item o_item
);
    import opf_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic [40:0] w_trial;

    always_comb begin
        n_item  = i_item;
        w_trial = {i_item.rem, i_item.d[BIT]};
        if (w_trial >= {1'b0, i_item.p}) begin
            w_trial = w_trial - {1'b0, i_item.p};
        end
        n_item.rem = w_trial[39:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

/* design/opf_checker.sv */
// opf_checker: port-level assertions for the orbit proximity filter
// bound to orbit_proximity_filter, depends on opf_if
module opf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_index,
    input logic        i_cfg_ready
);
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index))
        else $error("result dropped or changed under stall");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while pipeline stalled");

    a_in_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> !$isunknown(i_in_ready))
        else $error("input ready unknown while a transaction is offered");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");
endmodule

bind orbit_proximity_filter opf_checker u_opf_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_item.valid),
    .i_in_ready(i_item.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_out_index(o_res.matched_index),
    .i_cfg_ready(i_cfg.ready)
);

/* bench/tb_orbit_proximity_filter.sv */
// tb_orbit_proximity_filter: self-checking bench for the orbit proximity filter
// drives query loads and candidate tests, predicts each match flag, checks results in order
// depends on opf_pkg, opf_if and the orbit_proximity_filter rtl
`timescale 1ns / 100ps

module tb_orbit_proximity_filter;
    import opf_pkg::*;

    typedef struct {
        logic        opcode;
        logic [15:0] orbit_index;
        logic [31:0] q;
        logic [31:0] e;
        logic [31:0] inc;
        logic [31:0] node;
        logic [31:0] arg;
        logic [39:0] epoch;
        logic [39:0] period;
    } t_orbit;

    typedef struct {
        logic [15:0] idx;
        logic        close;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    opf_item_if item_ch ();
    opf_res_if  res_ch ();
    opf_cfg_if  cfg_ch ();

    orbit_proximity_filter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [31:0] lim_q, lim_e, lim_inc, lim_node, lim_arg;
    logic [23:0] lim_phase;
    logic [31:0] ref_q, ref_e, ref_inc, ref_node, ref_arg;
    logic [39:0] ref_epoch, ref_period;

    t_orbit   pending_orbits[$];
    t_verdict expected_verdicts[$];
    int       mismatches = 0;
    int       tests_seen = 0;
    int       close_seen = 0;
    bit       driving = 1'b0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_phase = 0;

    function automatic logic [31:0] fold(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        if (d > HalfTurn) d = -d;
        return d;
    endfunction

    function automatic bit phase_ok(logic [39:0] epoch);
        logic [39:0]  d;
        logic [40:0]  n;
        logic [39:0]  r;
        logic [127:0] lhs, rhs;
        if (ref_period == 0) return 1'b0;
        d = (epoch > ref_epoch) ? epoch - ref_epoch : ref_epoch - epoch;
        n = d / ref_period;
        r = d % ref_period;
        lhs = 128'(r) << 24;
        rhs = 128'(lim_phase) * (128'(n) + 1) * 128'(ref_period);
        return lhs < rhs;
    endfunction

    function automatic bit orbit_close(t_orbit o);
        bit ok;
        ok = 1'b1;
        if (ok && lim_phase != 0) ok = phase_ok(o.epoch);
        if (ok && lim_q != 0) ok = ((o.q > ref_q) ? o.q - ref_q : ref_q - o.q) < lim_q;
        if (ok && lim_e != 0) ok = ((o.e > ref_e) ? o.e - ref_e : ref_e - o.e) < lim_e;
        if (ok && lim_inc != 0) ok = fold(o.inc, ref_inc) < lim_inc;
        if (ok && lim_node != 0) ok = fold(o.node, ref_node) < lim_node;
        if (ok && lim_arg != 0 && ref_e > EccCircular) ok = fold(o.arg, ref_arg) < lim_arg;
        return ok;
    endfunction

    // predict on acceptance so config order stays exact
    task automatic predict_orbit(t_orbit o);
        t_verdict v;
        if (o.opcode == OP_LOAD) begin
            ref_q = o.q; ref_e = o.e; ref_inc = o.inc; ref_node = o.node;
            ref_arg = o.arg; ref_epoch = o.epoch; ref_period = o.period;
        end else begin
            v.idx = o.orbit_index;
            v.close = orbit_close(o);
            expected_verdicts.push_back(v);
        end
    endtask

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_orbit(pending_orbits.pop_front());
            end
            if ((!item_ch.valid || item_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end else if (driving && pending_orbits.size() != 0) begin
                    item_ch.valid               <= 1'b1;
                    item_ch.opcode              <= pending_orbits[0].opcode;
                    item_ch.orbit_index         <= pending_orbits[0].orbit_index;
                    item_ch.perihelion_distance <= pending_orbits[0].q;
                    item_ch.eccentricity        <= pending_orbits[0].e;
                    item_ch.inclination         <= pending_orbits[0].inc;
                    item_ch.ascending_node      <= pending_orbits[0].node;
                    item_ch.argument_perihelion <= pending_orbits[0].arg;
                    item_ch.perihelion_epoch    <= pending_orbits[0].epoch;
                    item_ch.orbital_period      <= pending_orbits[0].period;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                tests_seen++;
                if (res_ch.is_close) close_seen++;
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result idx=%h close=%b",
                                 res_ch.matched_index, res_ch.is_close);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (want.idx !== res_ch.matched_index || want.close !== res_ch.is_close) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected idx=%h close=%b, got idx=%h close=%b",
                                     want.idx, want.close, res_ch.matched_index,
                                     res_ch.is_close);
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 64;
            // stall-free first half, mixed stalls in second half
            res_ch.ready <= (stall_phase < 32) ? 1'b1 :
                            (stall_phase % 7 == 0 || $urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
        end
    end

    // valid stays high across back-to-back writes, the caller drops it
    task automatic write_limit(t_reg_index idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_PERIHELION:   lim_q = value;
            REG_ECCENTRICITY: lim_e = value;
            REG_INCLINATION:  lim_inc = value;
            REG_NODE:         lim_node = value;
            REG_ARGUMENT:     lim_arg = value;
            default:          lim_phase = value[23:0];
        endcase
    endtask

    task automatic set_limits(logic [31:0] lq, logic [31:0] le, logic [31:0] li,
                              logic [31:0] ln, logic [31:0] la, logic [31:0] lp);
        write_limit(REG_PERIHELION, lq);
        write_limit(REG_ECCENTRICITY, le);
        write_limit(REG_INCLINATION, li);
        write_limit(REG_NODE, ln);
        write_limit(REG_ARGUMENT, la);
        write_limit(REG_PHASE, lp);
        cfg_ch.valid <= 1'b0;
    endtask

    // drain and wait out the pipeline before touching registers
    task automatic run_queued();
        driving = 1'b1;
        while (pending_orbits.size() != 0 || expected_verdicts.size() != 0)
            @(posedge i_clk);
        driving = 1'b0;
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_orbit rand_orbit(logic op);
        t_orbit o;
        o.opcode = op;
        o.orbit_index = 16'($urandom);
        o.q = $urandom; o.e = $urandom; o.inc = $urandom;
        o.node = $urandom; o.arg = $urandom;
        o.epoch = 40'({$urandom, $urandom});
        o.period = 40'({$urandom, $urandom});
        return o;
    endfunction

    // candidate near the current query so limits decide the outcome
    function automatic t_orbit near_orbit(int spread);
        t_orbit o;
        int unsigned s;
        o = rand_orbit(OP_TEST);
        s = 1 << spread;
        o.q = ref_q + $urandom_range(0, s) - s / 2;
        o.e = ref_e + $urandom_range(0, s) - s / 2;
        o.inc = ref_inc + $urandom_range(0, s) - s / 2;
        o.node = ref_node + $urandom_range(0, s) - s / 2;
        o.arg = ref_arg + $urandom_range(0, s) - s / 2;
        if ($urandom_range(0, 1))
            o.epoch = ref_epoch + ref_period * $urandom_range(0, 5) + $urandom_range(0, s);
        return o;
    endfunction

    function automatic t_orbit load_orbit();
        t_orbit o;
        o = rand_orbit(OP_LOAD);
        o.period = {8'($urandom_range(0, 255)), $urandom};
        if ($urandom_range(0, 1)) o.e = $urandom_range(0, 32'd30000000);
        if ($urandom_range(0, 7) == 0) o.period = 0;
        o.epoch = o.epoch >> $urandom_range(0, 20);
        return o;
    endfunction

    initial begin
        t_orbit o;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_LOAD;
        item_ch.orbit_index = '0;
        item_ch.perihelion_distance = '0;
        item_ch.eccentricity = '0;
        item_ch.inclination = '0;
        item_ch.ascending_node = '0;
        item_ch.argument_perihelion = '0;
        item_ch.perihelion_epoch = '0;
        item_ch.orbital_period = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_PERIHELION;
        cfg_ch.data = '0;
        lim_q = 0; lim_e = 0; lim_inc = 0; lim_node = 0; lim_arg = 0; lim_phase = 0;
        ref_q = 0; ref_e = 0; ref_inc = 0; ref_node = 0; ref_arg = 0;
        ref_epoch = 0; ref_period = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: test before any load, all tests off
        o = rand_orbit(OP_TEST); o.orbit_index = 16'hFFFF; pending_orbits.push_back(o);
        o = rand_orbit(OP_TEST); o.orbit_index = 16'h0000; pending_orbits.push_back(o);
        run_queued();
        // zero period with time test on, plus max limits
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'hFF_FFFF);
        o = rand_orbit(OP_TEST); pending_orbits.push_back(o);
        o = '{OP_LOAD, 16'h1234, 32'h0100_0000, 32'h0800_0000, 32'h0, 32'hFFFF_FFFF,
              32'h8000_0000, 40'h0, 40'h0};
        pending_orbits.push_back(o);
        o.opcode = OP_TEST; pending_orbits.push_back(o);
        o.period = 40'hFF_FFFF_FFFF; o.opcode = OP_LOAD; o.epoch = 40'hFF_FFFF_FFFF;
        pending_orbits.push_back(o);
        // half turn exactly, opposite extremes of fields
        o = '{OP_TEST, 16'hA5A5, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0, 40'h0, 40'hFF_FFFF_FFFF};
        pending_orbits.push_back(o);
        o.epoch = 40'hFF_FFFF_FFFF; o.inc = 32'hFFFF_FFFF; pending_orbits.push_back(o);
        run_queued();
        // tight limits of one; eccentricity at the circular boundary
        set_limits(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
        o = '{OP_LOAD, 16'h0, 32'h10, 32'd13421772, 32'h20, 32'h30, 32'h40, 40'd1000,
              40'd100};
        pending_orbits.push_back(o);
        o.opcode = OP_TEST; o.arg = 32'h99; pending_orbits.push_back(o);
        o.epoch = 40'd1100; pending_orbits.push_back(o);
        o.opcode = OP_LOAD; o.e = 32'd13421773; pending_orbits.push_back(o);
        o.opcode = OP_TEST; pending_orbits.push_back(o);
        o.arg = 32'h40; pending_orbits.push_back(o);
        run_queued();

        // random phases with varied limits
        for (int ph = 0; ph < 10; ph++) begin
            int unsigned sh;
            sh = $urandom_range(4, 31);
            set_limits(($urandom_range(0, 3) == 0) ? 0 : $urandom >> $urandom_range(0, 31),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom >> $urandom_range(0, 31),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h8000_0000) >> $urandom_range(0, 20),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h8000_0000) >> $urandom_range(0, 20),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h8000_0000) >> $urandom_range(0, 20),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 24'hFF_FFFF));
            for (int k = 0; k < 53; k++) begin
                if (k == 0 || $urandom_range(0, 12) == 0) begin
                    o = load_orbit();
                    // track the query as the predictor will see it
                    ref_q = o.q; ref_e = o.e; ref_inc = o.inc; ref_node = o.node;
                    ref_arg = o.arg; ref_epoch = o.epoch; ref_period = o.period;
                end else if ($urandom_range(0, 4) == 0) begin
                    o = rand_orbit(OP_TEST);
                end else begin
                    o = near_orbit(sh);
                end
                pending_orbits.push_back(o);
            end
            run_queued();
        end

        $display("covered %0d candidate results (%0d close) over 13 limit settings",
                 tests_seen, close_seen);
        if (mismatches == 0)
            $display("tb_orbit_proximity_filter: clean");
        else
            $display("tb_orbit_proximity_filter: errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_orbit_proximity_filter: errors");
        $finish;
    end
endmodule
